[hdl/bounded_stack_calculator_top_assert.svh]
// assertion macros for the bounded stack calculator top level
// depends on aclk and aresetn being visible where the macros are used
`ifndef BOUNDED_STACK_CALCULATOR_TOP_ASSERT_SVH
`define BOUNDED_STACK_CALCULATOR_TOP_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define BSC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bsc assertion failed");

// next-cycle implication checked outside reset
`define BSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bsc assertion failed");

`endif

[hdl/bsc_pkg.sv]
// shared types and constants for the bounded stack calculator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bsc_pkg;
    localparam int unsigned STACK_DEPTH_DEF = 1024;
    localparam int unsigned VAL_W = 31;
    localparam int unsigned LIM_W = 30;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 30'd1000000000;

    typedef enum logic [3:0] {
        OP_START = 4'd0, OP_NUM = 4'd1, OP_POP = 4'd2, OP_INV = 4'd3,
        OP_DUP = 4'd4, OP_SWP = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7,
        OP_MUL = 4'd8, OP_DIV = 4'd9, OP_MOD = 4'd10, OP_FINISH = 4'd11
    } op_t;

    // datapath command from the controller
    typedef enum logic [3:0] {
        CMD_NONE, CMD_RD_TOP, CMD_RD_NEXT, CMD_EXEC, CMD_DIV_GO, CMD_WR_RES,
        CMD_WR_SWAP, CMD_FIN, CMD_START
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic fault;     // limit or zero-divisor fault of last exec
    } stat_t;
endpackage
`default_nettype wire

[hdl/bounded_stack_calculator_top.sv]
// push, pop, start, unused codes and underflow finish in idle; dup passes S_RD1, S_RD2, S_EXEC;
// inv, swp, add and sub add S_MULC; mul adds S_MULW then S_MULC; a zero divisor ends in S_MULW;
// div and mod wait in S_DIVW for the divider, one quotient bit a cycle over 31 bits, then S_DIVC
// finish loads the result register from S_FIN; it stalls only while an older result is unread
// one instruction at a time: a new request is taken only back in S_IDLE
// reset: synchronous active-low aresetn clears count, error and state and sets the limit to 1e9
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_stack_calculator_top_assert.svh"
module bounded_stack_calculator_top #(
    parameter int unsigned STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic s_tready,
    input  wire logic [39:0] s_tdata,  // [3:0] operation, [34:4] operand
    output logic m_tvalid,
    input  wire logic m_tready,
    output logic [31:0] m_tdata,       // [30:0] result_value
    output logic m_tuser,              // [0] error
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [29:0] cfg_data  // magnitude_limit
);
    import bsc_pkg::*;
    localparam int unsigned CNW = $clog2(STACK_DEPTH + 1);

    cmd_t cmd;
    stat_t stat;
    logic push_operand;
    logic [CNW-1:0] count;
    logic [LIM_W-1:0] limit_reg;
    logic [VAL_W-1:0] fin_value;
    logic out_error;
    logic out_load;

    // limit register, to be written only while idle; the block itself does not enforce this
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) limit_reg <= LIMIT_RESET;
        else if (cfg_valid) limit_reg <= cfg_data;
    end

    bsc_controller #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_op(s_tdata[3:0]), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_error(out_error), .out_load(out_load),
        .out_ready(m_tready),
        .cmd(cmd), .push_operand(push_operand), .count(count), .stat(stat)
    );

    bsc_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .count(count),
        .operand(s_tdata[34:4]), .push_operand(push_operand), .limit(limit_reg),
        .stat(stat), .fin_value(fin_value)
    );

    // result held in a register once latched from the memory read
    logic [VAL_W-1:0] res_reg;
    always_ff @(posedge aclk) begin
        if (out_load) res_reg <= fin_value;
    end
    assign m_tdata = {1'b0, out_error ? {VAL_W{1'b0}} : res_reg};
    assign m_tuser = out_error;

    `BSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `BSC_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNW'(STACK_DEPTH))
    `BSC_ASSERT_IMPL(a_err_zero, m_tvalid && m_tuser, m_tdata == '0)
endmodule
`default_nettype wire

[hdl/bsc_divider.sv]
// iterative signed divider, one quotient bit a cycle
// depends on bsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bsc_divider (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic start,
    input  wire logic [bsc_pkg::VAL_W-1:0] dividend,
    input  wire logic [bsc_pkg::VAL_W-1:0] divisor,
    output logic done,
    output logic [bsc_pkg::VAL_W-1:0] quotient,
    output logic [bsc_pkg::VAL_W-1:0] remainder
);
    import bsc_pkg::*;
    localparam int unsigned CW = $clog2(VAL_W + 1);

    logic [VAL_W-1:0] q_reg, d_reg;
    logic [VAL_W:0] r_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, qneg_reg, rneg_reg, done_reg;
    logic [VAL_W:0] trial;
    logic [VAL_W-1:0] na, nb;

    assign na = dividend[VAL_W-1] ? VAL_W'(-dividend) : dividend;
    assign nb = divisor[VAL_W-1] ? VAL_W'(-divisor) : divisor;
    assign trial = {r_reg[VAL_W-1:0], q_reg[VAL_W-1]} - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(VAL_W);
                q_reg <= na;
                d_reg <= nb;
                r_reg <= '0;
                qneg_reg <= dividend[VAL_W-1] ^ divisor[VAL_W-1];
                rneg_reg <= dividend[VAL_W-1];
            end else if (busy_reg) begin
                if (!trial[VAL_W]) begin
                    r_reg <= trial;
                    q_reg <= {q_reg[VAL_W-2:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[VAL_W-1:0], q_reg[VAL_W-1]};
                    q_reg <= {q_reg[VAL_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quotient = qneg_reg ? VAL_W'(-q_reg) : q_reg;
    assign remainder = rneg_reg ? VAL_W'(-r_reg[VAL_W-1:0]) : r_reg[VAL_W-1:0];
endmodule
`default_nettype wire

[hdl/bsc_datapath.sv]
// stack memory, operand registers, alu and divider
// depends on bsc_pkg and bsc_divider
`timescale 1ns / 1ps
`default_nettype none
module bsc_datapath #(
    parameter int unsigned STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire bsc_pkg::cmd_t cmd,
    input  wire logic [$clog2(STACK_DEPTH+1)-1:0] count,
    input  wire logic [bsc_pkg::VAL_W-1:0] operand,
    input  wire logic push_operand,
    input  wire logic [bsc_pkg::LIM_W-1:0] limit,
    output bsc_pkg::stat_t stat,
    output logic [bsc_pkg::VAL_W-1:0] fin_value
);
    import bsc_pkg::*;
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CNW = $clog2(STACK_DEPTH + 1);

    logic [VAL_W-1:0] mem [STACK_DEPTH];
    logic [VAL_W-1:0] rd_reg, a_reg, b_reg, res_reg;
    logic fault_reg;
    logic [2*VAL_W-1:0] prod_reg;
    logic mul_pend_reg;
    logic div_go;
    logic div_done;
    logic [VAL_W-1:0] quo, rem;
    logic [AW-1:0] top_addr, next_addr, wr_addr, rd_addr;
    logic [CNW-1:0] cm1, cm2;
    logic signed [VAL_W:0] sum;
    logic [VAL_W:0] sum_mag;
    logic signed [2*VAL_W-1:0] prod_mag;

    assign cm1 = count - 1'b1;
    assign cm2 = count - CNW'(2);
    assign top_addr = cm1[AW-1:0];
    assign next_addr = cm2[AW-1:0];
    assign rd_addr = (cmd.kind == CMD_RD_NEXT) ? next_addr
                   : (cmd.kind == CMD_FIN) ? '0 : top_addr;
    assign div_go = (cmd.kind == CMD_DIV_GO);

    always_comb begin
        if (cmd.op == OP_SUB) begin
            sum = $signed({b_reg[VAL_W-1], b_reg}) - $signed({a_reg[VAL_W-1], a_reg});
        end else begin
            sum = $signed({b_reg[VAL_W-1], b_reg}) + $signed({a_reg[VAL_W-1], a_reg});
        end
        sum_mag = sum[VAL_W] ? -sum : sum;
        prod_mag = prod_reg[2*VAL_W-1] ? -$signed(prod_reg) : $signed(prod_reg);
    end

    bsc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_go), .dividend(b_reg), .divisor(a_reg),
        .done(div_done), .quotient(quo), .remainder(rem)
    );

    // write port: pushes, alu result, swap and dup
    always_comb begin
        wr_addr = (cmd.kind == CMD_START) ? '0 : count[AW-1:0];
        if (cmd.kind == CMD_WR_RES) wr_addr = (cmd.op == OP_INV) ? top_addr : next_addr;
        else if (cmd.kind == CMD_WR_SWAP) wr_addr = next_addr;
    end

    always_ff @(posedge aclk) begin
        if (push_operand) mem[wr_addr] <= operand;
        else if (cmd.kind == CMD_WR_RES) mem[wr_addr] <= res_reg;
        else if (cmd.kind == CMD_WR_SWAP) mem[wr_addr] <= a_reg;
        else if (cmd.kind == CMD_EXEC && cmd.op == OP_DUP) mem[count[AW-1:0]] <= a_reg;
        else if (cmd.kind == CMD_EXEC && cmd.op == OP_SWP) mem[top_addr] <= b_reg;
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
        end else begin
            mul_pend_reg <= 1'b0;
            case (cmd.kind)
                CMD_RD_NEXT: a_reg <= rd_reg;
                CMD_EXEC: begin
                    // a_reg holds the top entry, b_reg the one below
                    case (cmd.op)
                        OP_INV: begin
                            res_reg <= VAL_W'(-a_reg);
                            fault_reg <= 1'b0;
                        end
                        OP_ADD, OP_SUB: begin
                            res_reg <= sum[VAL_W-1:0];
                            fault_reg <= sum_mag > {2'b00, limit};
                        end
                        OP_MUL: begin
                            prod_reg <= $signed(a_reg) * $signed(b_reg);
                            mul_pend_reg <= 1'b1;
                            fault_reg <= 1'b0;
                        end
                        OP_DIV, OP_MOD: fault_reg <= (a_reg == '0);
                        default: fault_reg <= 1'b0;
                    endcase
                end
                CMD_RD_TOP: b_reg <= rd_reg;
                default: ;
            endcase
            if (mul_pend_reg) begin
                res_reg <= prod_reg[VAL_W-1:0];
                fault_reg <= prod_mag > $signed({{(VAL_W+1){1'b0}}, limit});
            end
            if (div_done) res_reg <= (cmd.op == OP_MOD) ? rem : quo;
        end
    end

    assign stat.div_done = div_done;
    assign stat.fault = fault_reg;
    assign fin_value = rd_reg;
endmodule
`default_nettype wire

[hdl/bsc_controller.sv]
// sequencing state machine, stack count and sticky error
// depends on bsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bsc_controller #(
    parameter int unsigned STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    input  wire logic [3:0] in_op,
    output logic in_ready,
    output logic out_valid,
    output logic out_error,
    output logic out_load,
    input  wire logic out_ready,
    output bsc_pkg::cmd_t cmd,
    output logic push_operand,
    output logic [$clog2(STACK_DEPTH+1)-1:0] count,
    input  wire bsc_pkg::stat_t stat
);
    import bsc_pkg::*;
    localparam int unsigned CNW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD1, S_RD2, S_EXEC, S_MULW, S_MULC, S_DIVW, S_DIVC, S_FIN
    } state_t;

    state_t state_reg;
    logic [3:0] op_reg;
    logic [CNW-1:0] count_reg;
    logic err_reg, out_valid_reg, out_error_reg;
    logic need1, need2, accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept = in_valid && in_ready;
    assign need1 = (in_op == OP_POP) || (in_op == OP_INV) || (in_op == OP_DUP);
    assign need2 = (in_op >= OP_SWP) && (in_op <= OP_MOD);
    assign push_operand = accept && ((in_op == OP_START) ||
                          (in_op == OP_NUM && !err_reg && count_reg != CNW'(STACK_DEPTH)));
    // result register takes the finish once the previous result has gone
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb begin
        cmd.op = op_reg;
        unique case (state_reg)
            S_RD1: cmd.kind = CMD_RD_NEXT;
            S_RD2: cmd.kind = CMD_RD_TOP;
            S_EXEC: cmd.kind = CMD_EXEC;
            S_DIVW: cmd.kind = CMD_NONE;
            S_MULC, S_DIVC: cmd.kind = (op_reg == OP_SWP) ? CMD_WR_SWAP : CMD_WR_RES;
            S_FIN: cmd.kind = CMD_FIN;
            S_MULW: cmd.kind = ((op_reg == OP_DIV || op_reg == OP_MOD) && !stat.fault)
                               ? CMD_DIV_GO : CMD_NONE;
            default: cmd.kind = (accept && in_op == OP_FINISH) ? CMD_FIN
                              : (accept && in_op == OP_START) ? CMD_START : CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            err_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_error_reg <= 1'b0;
            op_reg <= '0;
        end else begin
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (accept) begin
                    op_reg <= in_op;
                    if (in_op == OP_START) begin
                        err_reg <= 1'b0;
                        count_reg <= CNW'(1);
                    end else if (in_op == OP_FINISH) begin
                        state_reg <= S_FIN;
                    end else if (!err_reg && in_op <= OP_MOD) begin
                        if (in_op == OP_NUM) begin
                            if (count_reg == CNW'(STACK_DEPTH)) err_reg <= 1'b1;
                            else count_reg <= count_reg + 1'b1;
                        end else if ((need1 && count_reg < CNW'(1)) ||
                                     (need2 && count_reg < CNW'(2))) begin
                            err_reg <= 1'b1;
                        end else if (in_op == OP_POP) begin
                            count_reg <= count_reg - 1'b1;
                        end else begin
                            state_reg <= S_RD1;
                        end
                    end
                end
                // S_RD1 latches the top as a and reads the next, S_RD2 latches the next as b
                S_RD1: state_reg <= S_RD2;
                S_RD2: state_reg <= S_EXEC;
                S_EXEC: begin
                    if (op_reg == OP_DUP) begin
                        if (count_reg == CNW'(STACK_DEPTH)) err_reg <= 1'b1;
                        else count_reg <= count_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end else if (op_reg == OP_SWP) begin
                        state_reg <= S_MULC;
                    end else if (op_reg == OP_INV || op_reg == OP_ADD || op_reg == OP_SUB) begin
                        state_reg <= S_MULC;
                    end else begin
                        state_reg <= S_MULW;
                    end
                end
                S_MULW: begin
                    if (op_reg == OP_MUL) state_reg <= S_MULC;
                    else if (stat.fault) begin
                        err_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else state_reg <= S_DIVW;
                end
                S_DIVW: if (stat.div_done) state_reg <= S_DIVC;
                S_MULC, S_DIVC: begin
                    // fault is valid here for add, sub, mul; div already checked
                    if (stat.fault && state_reg == S_MULC && op_reg != OP_SWP
                        && op_reg != OP_INV) begin
                        err_reg <= 1'b1;
                    end else if (op_reg != OP_SWP && op_reg != OP_INV) begin
                        count_reg <= count_reg - 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_FIN: begin
                    if (out_load) begin
                        out_error_reg <= err_reg || (count_reg != CNW'(1));
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_error = out_error_reg;
    assign count = count_reg;
endmodule
`default_nettype wire

[sim/bounded_stack_calculator_checker.sv]
// result checker for the bounded stack calculator: watches the instruction,
// result and limit channels, keeps its own stack, and compares every result
// depends on bsc_pkg
`timescale 1ns / 1ps
`default_nettype none
module bounded_stack_calculator_checker #(
    parameter int unsigned STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [29:0] cfg_data,
    output int               fail_count,
    output int               pending_results,
    output int               results_seen
);
    import bsc_pkg::*;

    typedef struct packed {
        logic [30:0] value;
        logic        err;
    } finish_t;

    finish_t          finish_queue[$];
    logic [30:0]      stk[STACK_DEPTH];
    int unsigned      depth;
    logic             sticky_err;
    logic [29:0]      mag_limit;

    function automatic longint sext(logic [30:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic push_word(longint v);
        if (depth >= STACK_DEPTH) begin
            sticky_err = 1'b1;
        end else begin
            stk[depth] = v[30:0];
            depth++;
        end
    endtask

    task automatic execute(logic [3:0] op, logic [30:0] operand);
        longint a, b, r;
        finish_t f;
        if (op == OP_START) begin
            depth = 0;
            sticky_err = 1'b0;
            push_word(sext(operand));
        end else if (op == OP_FINISH) begin
            if (sticky_err || depth != 1) begin
                f.value = '0;
                f.err = 1'b1;
            end else begin
                f.value = stk[0];
                f.err = 1'b0;
            end
            finish_queue = {finish_queue, f};
        end else if (op < OP_FINISH && !sticky_err) begin
            case (op)
                OP_NUM: push_word(sext(operand));
                OP_POP: if (depth < 1) sticky_err = 1'b1; else depth--;
                OP_INV: begin
                    if (depth < 1) sticky_err = 1'b1;
                    else stk[depth-1] = 31'(-sext(stk[depth-1]));
                end
                OP_DUP: begin
                    if (depth < 1) sticky_err = 1'b1;
                    else push_word(sext(stk[depth-1]));
                end
                default: begin
                    if (depth < 2) begin
                        sticky_err = 1'b1;
                    end else begin
                        a = sext(stk[depth-1]);
                        b = sext(stk[depth-2]);
                        if (op == OP_SWP) begin
                            stk[depth-1] = b[30:0];
                            stk[depth-2] = a[30:0];
                        end else if ((op == OP_DIV || op == OP_MOD) && a == 0) begin
                            sticky_err = 1'b1;
                        end else begin
                            case (op)
                                OP_ADD: r = b + a;
                                OP_SUB: r = b - a;
                                OP_MUL: r = b * a;
                                OP_DIV: r = b / a;
                                default: r = b % a;
                            endcase
                            if (op <= OP_MUL && absval(r) > longint'(mag_limit)) begin
                                sticky_err = 1'b1;
                            end else begin
                                depth -= 2;
                                push_word(r);
                            end
                        end
                    end
                end
            endcase
        end
    endtask

    assign pending_results = finish_queue.size();

    always @(posedge aclk) begin
        finish_t want;
        if (!aresetn) begin
            depth = 0;
            sticky_err = 1'b0;
            mag_limit = LIMIT_RESET;
            finish_queue.delete();
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (cfg_valid && cfg_ready) mag_limit = cfg_data;
            if (s_tvalid && s_tready) execute(s_tdata[3:0], s_tdata[34:4]);
            if (m_tvalid && m_tready) begin
                results_seen <= results_seen + 1;
                if (finish_queue.size() == 0) begin
                    $display("%0t: unexpected result value %0d error %0b", $realtime,
                             $signed(m_tdata[30:0]), m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = finish_queue.pop_front();
                    if (m_tdata[30:0] !== want.value || m_tuser !== want.err ||
                        m_tdata[31] !== 1'b0) begin
                        $display("%0t: mismatch expected value %0d error %0b,",
                                 $realtime, $signed(want.value), want.err,
                                 " actual value %0d error %0b",
                                 $signed(m_tdata[30:0]), m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

[sim/bounded_stack_calculator_top_tb.sv]
// stimulus and verdict for the bounded stack calculator top level
// depends on bsc_pkg, bounded_stack_calculator_top and the checker module
`timescale 1ns / 1ps
`default_nettype none
module bounded_stack_calculator_top_tb;
    import bsc_pkg::*;

    localparam int DEPTH = 64;         // small stack keeps the full-stack case short
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [29:0] cfg_data = '0;

    int fail_count, pending_results, results_seen;
    int cycle_count = 0;
    int requests_sent = 0;
    bit quiet_stretch = 1'b0;   // no idling on either side while set
    bit stim_done = 1'b0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    bounded_stack_calculator_top #(.STACK_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    bounded_stack_calculator_checker #(.STACK_DEPTH(DEPTH)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results),
        .results_seen(results_seen)
    );

    // watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side stalls about 13 percent of the time, except in a quiet stretch
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= quiet_stretch || ($urandom_range(99) >= 13);
    end

    // drop the request line before the sender pauses for anything else
    task automatic input_idle();
        s_tvalid <= 1'b0;
    endtask

    // one instruction request, held until accepted, with random gaps before it;
    // tvalid stays up afterwards so requests can follow back to back
    task automatic send_instr(logic [3:0] op, logic [30:0] operand);
        while (!quiet_stretch && $urandom_range(99) < 13) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, operand, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        @(negedge aclk);
    endtask

    // limit write only once the block is idle: results drained, divider settled
    task automatic write_limit(logic [29:0] lim);
        input_idle();
        while (pending_results != 0) @(negedge aclk);
        repeat (45) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [30:0] rand_operand();
        int unsigned k;
        k = $urandom_range(9);
        case (k)
            0: return 31'(-1000000000);
            1: return 31'(1000000000);
            2: return 31'($urandom_range(20)) - 31'd10;
            3: return 31'h4000_0000;          // most negative value
            4: return 31'($urandom);          // any bit pattern, outside range too
            default: return 31'($urandom_range(2000000)) - 31'd1000000;
        endcase
    endfunction

    // mostly well-formed programs: operations kept to the depth available
    task automatic run_program(int len);
        int d;
        int unsigned pick;
        logic [3:0] op;
        d = 1;
        send_instr(OP_START, rand_operand());
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) op = 4'($urandom_range(15));       // noise, broken programs
            else if (d < 2 || pick < 30) op = ($urandom_range(1)) ? OP_NUM : OP_DUP;
            else op = 4'($urandom_range(OP_POP, OP_MOD));
            case (op)
                OP_START: d = 1;
                OP_NUM, OP_DUP: d++;
                OP_POP: d--;
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: d--;
                default: ;
            endcase
            if (d < 0) d = 0;
            send_instr(op, rand_operand());
        end
        // fold to one entry most of the time
        if ($urandom_range(3) != 0) begin
            while (d > 1) begin
                send_instr(4'($urandom_range(OP_ADD, OP_MOD)), rand_operand());
                d--;
            end
        end
        send_instr(OP_FINISH, rand_operand());
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: finish with nothing pushed, each operation, each fault kind
        send_instr(OP_FINISH, '0);
        send_instr(OP_POP, '0);                          // underflow with empty stack
        send_instr(OP_START, 31'(1000000000));
        send_instr(OP_FINISH, '0);
        send_instr(OP_START, 31'h4000_0000);
        send_instr(OP_INV, '0);                          // wraps to itself
        send_instr(OP_FINISH, '0);
        send_instr(OP_START, 31'h4000_0000);
        send_instr(OP_NUM, 31'h7FFF_FFFF);               // -1
        send_instr(OP_DIV, '0);                          // wraps
        send_instr(OP_FINISH, '0);
        send_instr(OP_START, 31'(-7));
        send_instr(OP_NUM, 31'd2);
        send_instr(OP_MOD, '0);                          // remainder follows dividend
        send_instr(OP_NUM, 31'd5);
        send_instr(OP_SWP, '0);
        send_instr(OP_SUB, '0);
        send_instr(OP_DUP, '0);
        send_instr(OP_MUL, '0);
        send_instr(OP_FINISH, '0);
        send_instr(OP_START, 31'd9);
        send_instr(OP_NUM, 31'd0);
        send_instr(OP_DIV, '0);                          // zero divisor, sticky
        send_instr(OP_NUM, 31'd1);                       // ignored after fault
        send_instr(4'd13, '0);                           // unused code
        send_instr(OP_FINISH, '0);
        send_instr(OP_START, 31'(1000000000));
        send_instr(OP_DUP, '0);
        send_instr(OP_ADD, '0);                          // limit exceeded
        send_instr(OP_FINISH, '0);

        // full stack then one more push
        send_instr(OP_START, 31'd3);
        quiet_stretch = 1'b1;
        for (int i = 1; i < DEPTH; i++) send_instr(OP_DUP, '0);
        send_instr(OP_NUM, 31'd1);                       // overflow
        send_instr(OP_FINISH, '0);
        quiet_stretch = 1'b0;

        // limit settings, extremes among them
        write_limit(30'd0);
        send_instr(OP_START, 31'd0);
        send_instr(OP_NUM, 31'd0);
        send_instr(OP_ADD, '0);
        send_instr(OP_NUM, 31'd1);
        send_instr(OP_ADD, '0);
        send_instr(OP_FINISH, '0);
        write_limit(30'h3FFF_FFFF);
        for (int i = 0; i < 12; i++) run_program($urandom_range(2, 10));
        write_limit(30'd1000);
        for (int i = 0; i < 12; i++) run_program($urandom_range(2, 10));

        // hold off until every result is back
        input_idle();
        while (pending_results != 0) @(negedge aclk);
        write_limit(30'd1000000000);

        // random programs, one stretch without idling
        while (requests_sent < 640) begin
            if (requests_sent > 450 && requests_sent < 550)
                quiet_stretch = 1'b1;
            else
                quiet_stretch = 1'b0;
            run_program($urandom_range(1, 14));
        end
        input_idle();
        quiet_stretch = 1'b0;
        stim_done = 1'b1;
    end

    // verdict once stimulus is in and the block has drained
    initial begin
        wait (stim_done);
        while (pending_results != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        $display("covered %0d instruction requests and %0d finish results,", requests_sent,
                 results_seen);
        $display("including faults, a full stack and four limit settings");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
